### rtl/ssr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg
// shared sizes, input kind codes and controller/datapath interface structs
// for the subsequence score ranker
// ----------------------------------------------------------------------------
package ssr_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int MAX_QUERY   = 16;

    localparam int CHAR_W  = 8;
    localparam int FIELD_W = 5;
    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int QLEN_W  = $clog2(MAX_QUERY + 1);
    localparam int QIDX_W  = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int SCORE_W = QLEN_W;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_NAME  = 2'd2,
        KIND_EMIT  = 2'd3
    } kind_t;

    typedef struct packed {
        logic clear;
        logic query_wr;
        logic name_byte;
        logic name_end;
        logic emit_start;
        logic emit_next;
    } ssr_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic emit_last;
    } ssr_status_t;

endpackage

### rtl/ssr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_ctrl
// controller: decodes input transactions and sequences the ranking readout
// ----------------------------------------------------------------------------
module ssr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    input  ssr_pkg::kind_t      kind,
    input  logic                name_end,
    input  logic                m_ready,
    input  ssr_pkg::ssr_status_t status,
    output logic                s_ready,
    output logic                m_valid,
    output ssr_pkg::ssr_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_acc;
    logic   m_acc;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);
    assign s_acc   = s_valid && s_ready;
    assign m_acc   = m_valid && m_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.clear      = s_acc && (kind == ssr_pkg::KIND_CLEAR);
        cmd.query_wr   = s_acc && (kind == ssr_pkg::KIND_QUERY);
        cmd.name_byte  = s_acc && (kind == ssr_pkg::KIND_NAME);
        cmd.name_end   = name_end;
        cmd.emit_start = s_acc && (kind == ssr_pkg::KIND_EMIT) && !status.count_zero;
        cmd.emit_next  = m_acc;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.emit_start)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (m_acc && status.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/ssr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_datapath
// query store, running match, sorted insertion cell chain and readout mux
// ----------------------------------------------------------------------------
module ssr_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ssr_pkg::ssr_cmd_t              cmd,
    input  logic [ssr_pkg::CHAR_W-1:0]     char_value,
    output ssr_pkg::ssr_status_t           status,
    output logic [ssr_pkg::FIELD_W-1:0]    out_position,
    output logic [ssr_pkg::FIELD_W-1:0]    out_score,
    output logic                           out_overflow
);

    localparam int NE = ssr_pkg::MAX_ENTRIES;
    localparam int NQ = ssr_pkg::MAX_QUERY;
    localparam int IW = ssr_pkg::IDX_W;
    localparam int CW = ssr_pkg::CNT_W;
    localparam int LW = ssr_pkg::QLEN_W;
    localparam int QW = ssr_pkg::QIDX_W;
    localparam int SW = ssr_pkg::SCORE_W;
    localparam int FW = ssr_pkg::FIELD_W;

    logic [ssr_pkg::CHAR_W-1:0] query_mem [NQ];

    logic [LW-1:0] qlen_reg,  qlen_next;
    logic [SW-1:0] match_reg, match_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg,   ovf_next;
    logic [IW-1:0] idx_reg,   idx_next;

    logic [SW-1:0] cell_score_reg [NE];
    logic [IW-1:0] cell_pos_reg   [NE];
    logic [SW-1:0] cell_score_next [NE];
    logic [IW-1:0] cell_pos_next   [NE];
    logic [NE-1:0] keep;

    logic          query_room;
    logic          q_hit;
    logic [SW-1:0] match_upd;
    logic          store_full;
    logic          insert_en;
    logic [IW-1:0] new_pos;

    logic [SW+FW-1:0] score_ext;
    logic [IW+FW-1:0] pos_ext;

    assign query_room = (qlen_reg < LW'(NQ));
    assign q_hit      = (match_reg < qlen_reg) &&
                        (query_mem[match_reg[QW-1:0]] == char_value);
    assign match_upd  = q_hit ? (match_reg + SW'(1)) : match_reg;
    assign store_full = (count_reg == CW'(NE));
    assign insert_en  = cmd.name_byte && cmd.name_end && !store_full;
    assign new_pos    = count_reg[IW-1:0];

    // control registers
    always_comb
    begin
        qlen_next  = qlen_reg;
        match_next = match_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        if (cmd.clear)
        begin
            qlen_next  = '0;
            match_next = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (cmd.query_wr)
        begin
            if (query_room)
            begin
                qlen_next = qlen_reg + LW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        else if (cmd.name_byte)
        begin
            if (cmd.name_end)
            begin
                match_next = '0;
                if (store_full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            else
            begin
                match_next = match_upd;
            end
        end
        if (cmd.emit_start)
        begin
            idx_next = '0;
        end
        else if (cmd.emit_next)
        begin
            idx_next = idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg  <= '0;
            match_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            qlen_reg  <= qlen_next;
            match_reg <= match_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
        end
    end

    // query byte store
    always_ff @(posedge clk)
    begin
        if (cmd.query_wr && query_room)
        begin
            query_mem[qlen_reg[QW-1:0]] <= char_value;
        end
    end

    // sorted insertion: cells that outrank the new entry hold, the rest shift down
    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            keep[i] = (CW'(i) < count_reg) && (cell_score_reg[i] >= match_upd);
        end
        if (keep[0])
        begin
            cell_score_next[0] = cell_score_reg[0];
            cell_pos_next[0]   = cell_pos_reg[0];
        end
        else
        begin
            cell_score_next[0] = match_upd;
            cell_pos_next[0]   = new_pos;
        end
        for (int i = 1; i < NE; i++)
        begin
            if (keep[i])
            begin
                cell_score_next[i] = cell_score_reg[i];
                cell_pos_next[i]   = cell_pos_reg[i];
            end
            else if (keep[i-1])
            begin
                cell_score_next[i] = match_upd;
                cell_pos_next[i]   = new_pos;
            end
            else
            begin
                cell_score_next[i] = cell_score_reg[i-1];
                cell_pos_next[i]   = cell_pos_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert_en)
        begin
            for (int i = 0; i < NE; i++)
            begin
                cell_score_reg[i] <= cell_score_next[i];
                cell_pos_reg[i]   <= cell_pos_next[i];
            end
        end
    end

    // readout
    assign score_ext    = {{FW{1'b0}}, cell_score_reg[idx_reg]};
    assign pos_ext      = {{FW{1'b0}}, cell_pos_reg[idx_reg]};
    assign out_score    = score_ext[FW-1:0];
    assign out_position = pos_ext[FW-1:0];
    assign out_overflow = ovf_reg;

    assign status.count_zero = (count_reg == '0);
    assign status.emit_last  = ((CW'(idx_reg) + CW'(1)) == count_reg);

endmodule

### rtl/subsequence_score_ranker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subsequence_score_ranker
// fuzzy subsequence scoring of names against a query, kept in ranked order
// ----------------------------------------------------------------------------
// input stream: tuser = kind (clear, query byte, name byte, emit), tdata =
// byte, tlast = last byte of a name. while idle one transaction is taken
// every cycle; a name's final byte inserts it into the ranked cell chain in
// that same cycle, unless the chain is full, which sets the overflow flag.
// output stream: an emit with stored entries gives one transaction per
// entry, best score first and earlier arrival first on ties; tlast marks
// the final entry. the first result is shown the cycle after the emit is
// accepted, then one per cycle while tready is high.
// while results are pending the input side is held off (tready low); a
// stalled receiver simply holds the current result on the bus.
// reset empties the query and the ranking and clears the overflow flag;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module subsequence_score_ranker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_value[7:0]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // entry_position[4:0], score[9:5], overflow[10]
    output logic        m_axis_tlast
);

    ssr_pkg::ssr_cmd_t    cmd;
    ssr_pkg::ssr_status_t status;
    logic [ssr_pkg::FIELD_W-1:0] out_position;
    logic [ssr_pkg::FIELD_W-1:0] out_score;
    logic                        out_overflow;

    ssr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .kind     (ssr_pkg::kind_t'(s_axis_tuser)),
        .name_end (s_axis_tlast),
        .m_ready  (m_axis_tready),
        .status   (status),
        .s_ready  (s_axis_tready),
        .m_valid  (m_axis_tvalid),
        .cmd      (cmd)
    );

    ssr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .char_value   (s_axis_tdata),
        .status       (status),
        .out_position (out_position),
        .out_score    (out_score),
        .out_overflow (out_overflow)
    );

    assign m_axis_tdata = {5'b0, out_overflow, out_score, out_position};
    assign m_axis_tlast = status.emit_last;

endmodule

### rtl/ssr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_checker
// port-level checks on ranking readout, bound to the top level
// ----------------------------------------------------------------------------
module ssr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // no input taken while results are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted during readout");

    // readout ends right after the last entry
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("result after last entry");

    // readout continues without gaps and scores never rise
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[9:5] <= $past(m_axis_tdata[9:5])))
        else $error("ranking order broken");

    // overflow flag is steady across one readout
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tdata[10] == $past(m_axis_tdata[10]))
        else $error("overflow changed during readout");

endmodule

bind subsequence_score_ranker ssr_checker u_ssr_checker (.*);
